FILE: src/utf8_xml_char_validator_defines.svh
// Assertion macros for the UTF-8 XML character validator.
`ifndef UTF8_XML_CHAR_VALIDATOR_DEFINES_SVH
`define UTF8_XML_CHAR_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UTF8X_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8x assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UTF8X_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8x assertion failed");

`endif

FILE: src/utf8x_pkg.sv
// Shared types and constants for the UTF-8 XML character validator.
package utf8x_pkg;

  // Sequence lengths as kept in the decode state
  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenOne   = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  // Decode state carried from byte to byte
  typedef struct packed {
    logic [1:0]  pending;   // continuation bytes still expected
    logic [2:0]  seq_len;   // length of the sequence in progress
    logic [20:0] cp;        // code point bits gathered so far
    logic        err;       // string already known invalid
  } state_t;

  localparam state_t StateReset = '{pending: 2'd0, seq_len: LenNone, cp: 21'd0, err: 1'b0};

endpackage

FILE: src/utf8x_if.sv
// Request and result channel interfaces of the UTF-8 XML character validator.
interface utf8x_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       last;

  modport source (output valid, output byte_value, output byte_present, output last,
                  input ready);
  modport sink   (input valid, input byte_value, input byte_present, input last,
                  output ready);
endinterface

interface utf8x_out_if;
  logic valid;
  logic ready;
  logic string_valid;

  modport source (output valid, output string_valid, input ready);
  modport sink   (input valid, input string_valid, output ready);
endinterface

FILE: src/utf8_xml_char_validator.sv
// UTF-8 XML character validator: takes one byte per request at up to one request per
// cycle and returns one verdict for each request marked last, in the cycle after it is
// accepted. The decode state and the verdict register are updated at the edge where a
// request is accepted; the request side is held off only while a verdict waits in the
// result register and the result side is stalled. An errored string stays invalid
// until its last request, after which the state returns to its reset value.
`include "utf8_xml_char_validator_defines.svh"

module utf8_xml_char_validator
  import utf8x_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  utf8x_in_if.sink         req_i,
  utf8x_out_if.source      res_o
);

  state_t state_q, state_d, step_nxt;
  logic   res_valid_q, res_valid_d;
  logic   res_bit_q, res_bit_d;
  logic   req_fire, req_ready;

  utf8x_step u_step (
    .cur_i         (state_q),
    .byte_value_i  (req_i.byte_value),
    .byte_present_i(req_i.byte_present),
    .nxt_o         (step_nxt)
  );

  // Accept while the result register is empty or draining this cycle
  assign req_ready   = !res_valid_q || res_o.ready;
  assign req_i.ready = req_ready;
  assign req_fire    = req_i.valid && req_ready;

  // State and verdict update
  always_comb begin
    state_d     = state_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_bit_d   = res_bit_q;
    if (req_fire) begin
      if (req_i.last) begin
        state_d     = StateReset;
        res_valid_d = 1'b1;
        res_bit_d   = !step_nxt.err && (step_nxt.pending == 2'd0);
      end else begin
        state_d = step_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_bit_q <= res_bit_d;
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.string_valid = res_bit_q;

  // Checks
  `UTF8X_ASSERT_NEXT(a_last_gives_result, req_fire && req_i.last, res_valid_q)
  `UTF8X_ASSERT_NEXT(a_last_clears_state, req_fire && req_i.last,
                     state_q.pending == 2'd0 && !state_q.err && state_q.seq_len == LenNone)
  `UTF8X_ASSERT(a_pending_below_len, state_q.pending != 2'd0,
                {1'b0, state_q.pending} < state_q.seq_len)
  `UTF8X_ASSERT(a_stall_only_when_full, !req_ready, res_valid_q && !res_o.ready)

endmodule

FILE: src/utf8x_step.sv
// Next-state logic: decodes one byte and checks completed code points.
module utf8x_step
  import utf8x_pkg::*;
(
  input  state_t     cur_i,
  input  logic [7:0] byte_value_i,
  input  logic       byte_present_i,
  output state_t     nxt_o
);

  localparam logic [20:0] CpMax       = 21'h10FFFF;
  localparam logic [20:0] SurrLow     = 21'h00D800;
  localparam logic [20:0] SurrHigh    = 21'h00DFFF;
  localparam logic [20:0] NonCharFffe = 21'h00FFFE;
  localparam logic [20:0] NonCharFfff = 21'h00FFFF;
  localparam logic [20:0] Min2Byte    = 21'h000080;
  localparam logic [20:0] Min3Byte    = 21'h000800;
  localparam logic [20:0] Min4Byte    = 21'h010000;
  localparam logic [20:0] CtrlLimit   = 21'h000020;
  localparam logic [20:0] CharTab     = 21'h000009;
  localparam logic [20:0] CharLf      = 21'h00000A;
  localparam logic [20:0] CharCr      = 21'h00000D;

  // XML character rule plus overlong check for a finished code point
  function automatic logic char_allowed(logic [20:0] cp, logic [2:0] len);
    logic ok;
    ok = 1'b1;
    if ((len == LenTwo && cp < Min2Byte) || (len == LenThree && cp < Min3Byte) ||
        (len == LenFour && cp < Min4Byte)) ok = 1'b0;
    if (cp > CpMax) ok = 1'b0;
    if (cp >= SurrLow && cp <= SurrHigh) ok = 1'b0;
    if (cp < CtrlLimit && cp != CharTab && cp != CharLf && cp != CharCr) ok = 1'b0;
    if (cp == NonCharFffe || cp == NonCharFfff) ok = 1'b0;
    return ok;
  endfunction

  logic [20:0] cp_shift;

  assign cp_shift = {cur_i.cp[14:0], byte_value_i[5:0]};

  // One byte of decode; errors are sticky until the end of the string
  always_comb begin
    nxt_o = cur_i;
    if (byte_present_i && !cur_i.err) begin
      if (cur_i.pending == 2'd0) begin
        if (!byte_value_i[7]) begin
          if (!char_allowed({13'd0, byte_value_i}, LenOne)) nxt_o.err = 1'b1;
        end else if (byte_value_i[7:5] == 3'b110) begin
          nxt_o.pending = 2'd1;
          nxt_o.seq_len = LenTwo;
          nxt_o.cp      = {16'd0, byte_value_i[4:0]};
        end else if (byte_value_i[7:4] == 4'b1110) begin
          nxt_o.pending = 2'd2;
          nxt_o.seq_len = LenThree;
          nxt_o.cp      = {17'd0, byte_value_i[3:0]};
        end else if (byte_value_i[7:3] == 5'b11110) begin
          nxt_o.pending = 2'd3;
          nxt_o.seq_len = LenFour;
          nxt_o.cp      = {18'd0, byte_value_i[2:0]};
        end else begin
          // stray continuation or lead byte F8 and above
          nxt_o.err = 1'b1;
        end
      end else if (byte_value_i[7:6] != 2'b10) begin
        nxt_o.err = 1'b1;
      end else begin
        nxt_o.pending = cur_i.pending - 2'd1;
        if (cur_i.pending == 2'd1) begin
          if (!char_allowed(cp_shift, cur_i.seq_len)) nxt_o.err = 1'b1;
          nxt_o.cp      = 21'd0;
          nxt_o.seq_len = LenNone;
        end else begin
          nxt_o.cp = cp_shift;
        end
      end
    end
  end

endmodule
